@@ sv/dcht_pkg.sv @@
// ----------------------------------------------------------------------------
// dcht_pkg
// Shared constants for the duty-cycled hysteresis thermostat core: default
// widths, fixed register widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package dcht_pkg;

   // default widths of temperature and time values
   localparam int DEF_TEMP_BITS = 12;
   localparam int DEF_TIME_BITS = 32;

   // fixed widths of the timing registers
   localparam int PERIOD_BITS = 16;
   localparam int PHASE_BITS  = 24;

   // register index port width
   localparam int CSR_IDX_BITS = 3;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLED     = 3'd0,
      CSR_TARGET_TEMP = 3'd1,
      CSR_BAND_HALF   = 3'd2,
      CSR_READ_PERIOD = 3'd3,
      CSR_HEAT_PHASE  = 3'd4,
      CSR_REST_PHASE  = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic                   RST_ENABLED     = 1'b0;
   localparam logic [PERIOD_BITS-1:0] RST_READ_PERIOD = 16'd1000;
   localparam logic [PHASE_BITS-1:0]  RST_HEAT_PHASE  = 24'd60000;
   localparam logic [PHASE_BITS-1:0]  RST_REST_PHASE  = 24'd30000;
   localparam int                     RST_BAND_HALF   = 16;

endpackage

@@ sv/dcht_step.sv @@
// ----------------------------------------------------------------------------
// dcht_step
// Next-state logic for one controller call: reading capture, heat/rest phase
// timer and hysteresis latch of the Peltier drive.
// ----------------------------------------------------------------------------
module dcht_step #(
   parameter int TEMP_BITS = dcht_pkg::DEF_TEMP_BITS,
   parameter int TIME_BITS = dcht_pkg::DEF_TIME_BITS
) (
   // request fields
   input  logic [TIME_BITS-1:0]              now_ms,
   input  logic signed [TEMP_BITS-1:0]       sensor_temp,
   // current state
   input  logic signed [TEMP_BITS-1:0]       captured_temp,
   input  logic [TIME_BITS-1:0]              last_capture_time,
   input  logic [TIME_BITS-1:0]              last_phase_time,
   input  logic                              heat_phase,
   input  logic                              peltier_latch,
   // configuration
   input  logic                              enabled,
   input  logic signed [TEMP_BITS-1:0]       target_temp,
   input  logic [TEMP_BITS-2:0]              band_half_width,
   input  logic [dcht_pkg::PERIOD_BITS-1:0]  read_period_ms,
   input  logic [dcht_pkg::PHASE_BITS-1:0]   heat_phase_ms,
   input  logic [dcht_pkg::PHASE_BITS-1:0]   rest_phase_ms,
   // next state
   output logic signed [TEMP_BITS-1:0]       captured_temp_next,
   output logic [TIME_BITS-1:0]              last_capture_time_next,
   output logic [TIME_BITS-1:0]              last_phase_time_next,
   output logic                              heat_phase_next,
   output logic                              peltier_latch_next,
   output logic                              fan_on
);
   import dcht_pkg::*;

   localparam int CMP_W = (TIME_BITS > PHASE_BITS) ? TIME_BITS : PHASE_BITS;
   localparam int WT    = TEMP_BITS + 1;

   logic [TIME_BITS-1:0]    cap_elapsed;
   logic                    take_reading;
   logic [TIME_BITS-1:0]    phase_elapsed;
   logic [TIME_BITS-1:0]    phase_elapsed_after;
   logic                    heat_done;
   logic                    heat_after;
   logic                    heat_start;
   logic signed [WT-1:0]    cur_w;
   logic signed [WT-1:0]    tgt_w;
   logic signed [WT-1:0]    band_w;
   logic signed [WT-1:0]    upper_w;
   logic signed [WT-1:0]    lower_w;

   // capture the reading once more than the read period has gone by
   always_comb begin
      cap_elapsed  = now_ms - last_capture_time;
      take_reading = CMP_W'(cap_elapsed) > CMP_W'(read_period_ms);
      captured_temp_next     = take_reading ? sensor_temp : captured_temp;
      last_capture_time_next = take_reading ? now_ms : last_capture_time;
   end

   // heat phase may end and the rest phase restart within the same call
   always_comb begin
      phase_elapsed       = now_ms - last_phase_time;
      heat_done           = enabled && heat_phase &&
                            (CMP_W'(phase_elapsed) >= CMP_W'(heat_phase_ms));
      phase_elapsed_after = heat_done ? '0 : phase_elapsed;
      heat_after          = heat_phase && !heat_done;
      heat_start          = enabled && !heat_after &&
                            (CMP_W'(phase_elapsed_after) >= CMP_W'(rest_phase_ms));
      heat_phase_next     = heat_after || heat_start;
      last_phase_time_next = (heat_done || heat_start) ? now_ms : last_phase_time;
      fan_on              = enabled && heat_phase_next;
   end

   // hysteresis thresholds one bit wider than a temperature
   always_comb begin
      cur_w   = $signed({captured_temp_next[TEMP_BITS-1], captured_temp_next});
      tgt_w   = $signed({target_temp[TEMP_BITS-1], target_temp});
      band_w  = $signed({2'b00, band_half_width});
      upper_w = tgt_w + band_w;
      lower_w = tgt_w - band_w;
      peltier_latch_next = peltier_latch;
      if (!fan_on) begin
         peltier_latch_next = 1'b0;
      end else begin
         if (cur_w > upper_w) begin
            peltier_latch_next = 1'b0;
         end
         if (cur_w < lower_w) begin
            peltier_latch_next = 1'b1;
         end
      end
   end

endmodule

@@ sv/duty_cycled_hysteresis_thermostat_core.sv @@
// ----------------------------------------------------------------------------
// duty_cycled_hysteresis_thermostat_core
// Bang-bang thermostat with hysteresis band and a heat/rest duty-cycle timer.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_now_ms, req_sensor_temp
// rsp       out  rsp_valid/rsp_ready    rsp_peltier_on, rsp_fan_on,
//                                       rsp_held_temp, rsp_in_heat_phase
// csr       in   csr_wr_en              csr_index, csr_wdata
//
// A request is taken into an input register, evaluated by the step logic in
// the next cycle and written with the state update into the response
// register; one request per cycle sustained unless the response stalls.
// Synchronous reset clears the state, the registers to their reset values
// and both valid flags. A stalled response holds the input register only
// while it is full; req_ready stays high whenever the pipeline can move.
//
module duty_cycled_hysteresis_thermostat_core #(
   parameter int TEMP_BITS = dcht_pkg::DEF_TEMP_BITS,
   parameter int TIME_BITS = dcht_pkg::DEF_TIME_BITS,
   parameter int CSR_W     = (TEMP_BITS > dcht_pkg::PHASE_BITS) ?
                             TEMP_BITS : dcht_pkg::PHASE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [TIME_BITS-1:0]                req_now_ms,
   input  logic signed [TEMP_BITS-1:0]         req_sensor_temp,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_peltier_on,
   output logic                                rsp_fan_on,
   output logic signed [TEMP_BITS-1:0]         rsp_held_temp,
   output logic                                rsp_in_heat_phase,
   // configuration port
   input  logic                                csr_wr_en,
   input  logic [dcht_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_W-1:0]                    csr_wdata
);
   import dcht_pkg::*;

   // configuration registers
   logic                          enabled_ff;
   logic signed [TEMP_BITS-1:0]   target_ff;
   logic [TEMP_BITS-2:0]          band_ff;
   logic [PERIOD_BITS-1:0]        period_ff;
   logic [PHASE_BITS-1:0]         heat_len_ff;
   logic [PHASE_BITS-1:0]         rest_len_ff;

   // controller state
   logic signed [TEMP_BITS-1:0]   captured_ff,   captured_in;
   logic [TIME_BITS-1:0]          cap_time_ff,   cap_time_in;
   logic [TIME_BITS-1:0]          phase_time_ff, phase_time_in;
   logic                          heat_ff,       heat_in;
   logic                          latch_ff,      latch_in;
   logic                          fan_in;

   // input register
   logic                          s1_valid_ff;
   logic [TIME_BITS-1:0]          s1_now_ff;
   logic signed [TEMP_BITS-1:0]   s1_temp_ff;

   logic                          s1_advance;
   logic                          req_take;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= RST_ENABLED;
         target_ff   <= '0;
         band_ff     <= (TEMP_BITS-1)'(RST_BAND_HALF);
         period_ff   <= RST_READ_PERIOD;
         heat_len_ff <= RST_HEAT_PHASE;
         rest_len_ff <= RST_REST_PHASE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLED:     enabled_ff  <= csr_wdata[0];
            CSR_TARGET_TEMP: target_ff   <= $signed(csr_wdata[TEMP_BITS-1:0]);
            CSR_BAND_HALF:   band_ff     <= csr_wdata[TEMP_BITS-2:0];
            CSR_READ_PERIOD: period_ff   <= csr_wdata[PERIOD_BITS-1:0];
            CSR_HEAT_PHASE:  heat_len_ff <= csr_wdata[PHASE_BITS-1:0];
            CSR_REST_PHASE:  rest_len_ff <= csr_wdata[PHASE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign s1_advance = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_now_ff  <= req_now_ms;
         s1_temp_ff <= req_sensor_temp;
      end
   end

   // step logic
   dcht_step #(
      .TEMP_BITS (TEMP_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .now_ms                 (s1_now_ff),
      .sensor_temp            (s1_temp_ff),
      .captured_temp          (captured_ff),
      .last_capture_time      (cap_time_ff),
      .last_phase_time        (phase_time_ff),
      .heat_phase             (heat_ff),
      .peltier_latch          (latch_ff),
      .enabled                (enabled_ff),
      .target_temp            (target_ff),
      .band_half_width        (band_ff),
      .read_period_ms         (period_ff),
      .heat_phase_ms          (heat_len_ff),
      .rest_phase_ms          (rest_len_ff),
      .captured_temp_next     (captured_in),
      .last_capture_time_next (cap_time_in),
      .last_phase_time_next   (phase_time_in),
      .heat_phase_next        (heat_in),
      .peltier_latch_next     (latch_in),
      .fan_on                 (fan_in)
   );

   // state update when the request leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         captured_ff   <= '0;
         cap_time_ff   <= '0;
         phase_time_ff <= '0;
         heat_ff       <= 1'b0;
         latch_ff      <= 1'b0;
      end else if (s1_advance) begin
         captured_ff   <= captured_in;
         cap_time_ff   <= cap_time_in;
         phase_time_ff <= phase_time_in;
         heat_ff       <= heat_in;
         latch_ff      <= latch_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_peltier_on    <= latch_in;
         rsp_fan_on        <= fan_in;
         rsp_held_temp     <= captured_in;
         rsp_in_heat_phase <= heat_in;
      end
   end

   // checks
   a_fan_needs_heat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fan_on |-> rsp_in_heat_phase)
      else $error("fan on outside the heating phase");

   a_peltier_needs_fan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_peltier_on |-> rsp_fan_on)
      else $error("peltier on without the fan");

   a_full_pipe_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the pipeline is full");

   a_disabled_drives_off: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !enabled_ff |=> !latch_ff && !rsp_fan_on)
      else $error("drive on while disabled");

endmodule

@@ test/duty_cycled_hysteresis_thermostat_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty_cycled_hysteresis_thermostat_core_test
// Self-checking bench for the thermostat core. Requests are sent in bursts
// with random gaps while the response side stalls on its own pattern. A
// built-in predictor tracks the capture timer, the heat/rest duty cycle and
// the hysteresis latch, and each response is checked field by field against
// the oldest prediction. Directed cases come first, then long runs of
// well-formed time sequences under changing register settings.
// ----------------------------------------------------------------------------
module duty_cycled_hysteresis_thermostat_core_test;
   import dcht_pkg::*;

   localparam int TEMP_W   = DEF_TEMP_BITS;
   localparam int TIME_W   = DEF_TIME_BITS;
   localparam int BAND_W   = TEMP_W - 1;
   localparam int CSR_W    = (TEMP_W > PHASE_BITS) ? TEMP_W : PHASE_BITS;
   localparam int TEMP_MAX = 2 ** (TEMP_W - 1) - 1;
   localparam int TEMP_MIN = -(2 ** (TEMP_W - 1));

   // indexes past the register list, writes there are dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_LO = CSR_IDX_BITS'(6);
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_HI = CSR_IDX_BITS'(7);

   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BACKLOG_ITEMS    = 40;
   localparam int RANDOM_ITEMS     = 1830;
   localparam int CYCLE_LIMIT      = 500000;

   typedef struct {
      logic                     peltier_on;
      logic                     fan_on;
      logic signed [TEMP_W-1:0] held_temp;
      logic                     in_heat_phase;
   } drive_outputs_type;

   // dut ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic signed [TEMP_W-1:0]  req_sensor_temp = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_peltier_on;
   logic                      rsp_fan_on;
   logic signed [TEMP_W-1:0]  rsp_held_temp;
   logic                      rsp_in_heat_phase;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;

   // predictor copy of the registers
   logic                      cfg_enabled     = RST_ENABLED;
   logic signed [TEMP_W-1:0]  cfg_target      = '0;
   logic [BAND_W-1:0]         cfg_band        = BAND_W'(RST_BAND_HALF);
   logic [PERIOD_BITS-1:0]    cfg_read_period = RST_READ_PERIOD;
   logic [PHASE_BITS-1:0]     cfg_heat_ms     = RST_HEAT_PHASE;
   logic [PHASE_BITS-1:0]     cfg_rest_ms     = RST_REST_PHASE;

   // predictor copy of the controller state
   logic signed [TEMP_W-1:0]  held_reading    = '0;
   logic [TIME_W-1:0]         last_capture_ms = '0;
   logic [TIME_W-1:0]         phase_start_ms  = '0;
   logic                      heating         = 1'b0;
   logic                      peltier_latched = 1'b0;

   drive_outputs_type         expected_drives[$];
   int                        mismatch_count = 0;
   int                        cycle_count = 0;
   int                        burst_left = 0;
   logic [TIME_W-1:0]         wall_ms = '0;

   // receiver stall control
   int                        holds_asked = 0;
   int                        holds_done = 0;
   int                        hold_left = 0;
   int                        segment_left = 0;
   int                        ready_pct = 100;

   duty_cycled_hysteresis_thermostat_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_ms        (req_now_ms),
      .req_sensor_temp   (req_sensor_temp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_peltier_on    (rsp_peltier_on),
      .rsp_fan_on        (rsp_fan_on),
      .rsp_held_temp     (rsp_held_temp),
      .rsp_in_heat_phase (rsp_in_heat_phase),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one controller call: capture, duty-cycle timer, hysteresis latch
   function automatic drive_outputs_type thermostat_step(
         input logic [TIME_W-1:0] now,
         input logic signed [TEMP_W-1:0] reading);
      drive_outputs_type d;
      logic [TIME_W-1:0] elapsed;
      int                cur;
      int                tgt;
      int                band;
      // capture only when strictly more than the read period has passed
      elapsed = now - last_capture_ms;
      if (elapsed > TIME_W'(cfg_read_period)) begin
         held_reading    = reading;
         last_capture_ms = now;
      end
      d.fan_on = 1'b0;
      if (cfg_enabled) begin
         // heat ends first, then rest is checked again in the same call
         elapsed = now - phase_start_ms;
         if (heating && elapsed >= TIME_W'(cfg_heat_ms)) begin
            heating        = 1'b0;
            phase_start_ms = now;
            elapsed        = '0;
         end
         if (!heating && elapsed >= TIME_W'(cfg_rest_ms)) begin
            heating        = 1'b1;
            phase_start_ms = now;
         end
         if (heating) begin
            // thresholds at full precision, never wrap
            cur  = held_reading;
            tgt  = cfg_target;
            band = cfg_band;
            if (cur > tgt + band)
               peltier_latched = 1'b0;
            if (cur < tgt - band)
               peltier_latched = 1'b1;
            d.fan_on = 1'b1;
         end else begin
            peltier_latched = 1'b0;
         end
      end else begin
         peltier_latched = 1'b0;
      end
      d.peltier_on    = peltier_latched;
      d.held_temp     = held_reading;
      d.in_heat_phase = heating;
      return d;
   endfunction

   // random phase or period length, extremes included
   function automatic logic [CSR_W-1:0] pick_span(input logic [CSR_W-1:0] top);
      case ($urandom_range(5))
         0:       return '0;
         1:       return top;
         5:       return CSR_W'($urandom) & top;
         default: return CSR_W'($urandom_range(80));
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin : check_responses
      drive_outputs_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_peltier_on !== want.peltier_on) begin
               $error("peltier_on: expected %0d, actual %0d", want.peltier_on, rsp_peltier_on);
               mismatch_count++;
            end
            if (rsp_fan_on !== want.fan_on) begin
               $error("fan_on: expected %0d, actual %0d", want.fan_on, rsp_fan_on);
               mismatch_count++;
            end
            if (rsp_held_temp !== want.held_temp) begin
               $error("held_temp: expected %0d, actual %0d", want.held_temp, rsp_held_temp);
               mismatch_count++;
            end
            if (rsp_in_heat_phase !== want.in_heat_phase) begin
               $error("in_heat_phase: expected %0d, actual %0d",
                      want.in_heat_phase, rsp_in_heat_phase);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls: random segments, plus long hold-offs on demand
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_ready  <= 1'b0;
         hold_left  <= LONG_HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         if (segment_left == 0) begin
            case ($urandom_range(2))
               0:       ready_pct <= 100;
               1:       ready_pct <= 60;
               default: ready_pct <= 25;
            endcase
            segment_left <= $urandom_range(200, 10);
         end else begin
            segment_left <= segment_left - 1;
         end
         rsp_ready <= ($urandom_range(99) < ready_pct);
      end
   end

   // offer one request and hold it until taken
   task automatic send_request(input logic [TIME_W-1:0] now,
                               input logic signed [TEMP_W-1:0] reading);
      req_valid       <= 1'b1;
      req_now_ms      <= now;
      req_sensor_temp <= reading;
      do @(posedge clock); while (!req_ready);
      expected_drives.push_back(thermostat_step(now, reading));
   endtask

   // sender bursts with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(24, 1);
         case ($urandom_range(3))
            0:       gap = 0;
            1:       gap = $urandom_range(2, 1);
            2:       gap = $urandom_range(8, 3);
            default: gap = $urandom_range(30, 9);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending and wait until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, mirrored into the predictor with width masking
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                 input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_ENABLED:     cfg_enabled     = data[0];
         CSR_TARGET_TEMP: cfg_target      = data[TEMP_W-1:0];
         CSR_BAND_HALF:   cfg_band        = data[BAND_W-1:0];
         CSR_READ_PERIOD: cfg_read_period = data[PERIOD_BITS-1:0];
         CSR_HEAT_PHASE:  cfg_heat_ms     = data[PHASE_BITS-1:0];
         CSR_REST_PHASE:  cfg_rest_ms     = data[PHASE_BITS-1:0];
         default:         ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] enabled_w, target_w, band_w,
                                 period_w, heat_w, rest_w);
      wait_drained();
      write_register(CSR_ENABLED, enabled_w);
      write_register(CSR_TARGET_TEMP, target_w);
      write_register(CSR_BAND_HALF, band_w);
      write_register(CSR_READ_PERIOD, period_w);
      write_register(CSR_HEAT_PHASE, heat_w);
      write_register(CSR_REST_PHASE, rest_w);
   endtask

   // reset values: capture window with wrap-around, block disabled
   task automatic test_capture_after_reset();
      send_request('0, TEMP_W'(TEMP_MAX));
      send_request(TIME_W'(1000), TEMP_W'(TEMP_MIN));
      send_request(TIME_W'(1001), TEMP_W'(TEMP_MIN));
      send_request('1, TEMP_W'(TEMP_MAX));
   endtask

   // upper bits dropped, unmapped indexes ignored
   task automatic test_register_masking();
      apply_settings(24'hFF_FFFE, 24'hABC_7FF, 24'hFFF_805, 24'hFF_03E8,
                     24'h00_0040, 24'h00_0020);
      write_register(CSR_UNMAPPED_LO, '1);
      write_register(CSR_UNMAPPED_HI, '1);
      write_register(CSR_ENABLED, '1);
      wall_ms = 32'h0000_2000;
      send_request(wall_ms, 12'sh155);
      wall_ms += 1001;
      send_request(wall_ms, 12'shAAA);
   endtask

   // phase boundaries at exactly the programmed lengths
   task automatic test_duty_cycle_timing();
      apply_settings(1, 0, 16, 0, 10, 5);
      wall_ms = 32'h0001_0000;
      send_request(wall_ms, 10);
      // same time twice, no capture with zero period
      send_request(wall_ms, 20);
      wall_ms += 10;
      send_request(wall_ms, 30);
      wall_ms += 5;
      send_request(wall_ms, 40);
      wall_ms += 10;
      send_request(wall_ms, 50);
      // zero rest: heating restarts at once
      apply_settings(1, 0, 16, 0, 10, 0);
      wall_ms += 10;
      send_request(wall_ms, 60);
      // zero heat and zero rest
      apply_settings(1, 0, 16, 0, 0, 0);
      wall_ms += 1;
      send_request(wall_ms, 70);
   endtask

   // latch switching, dead band, extreme thresholds
   task automatic test_hysteresis_band();
      apply_settings(1, 100, 20, 0, 24'hFF_FFFF, 0);
      wall_ms += 1; send_request(wall_ms, 79);
      wall_ms += 1; send_request(wall_ms, 100);
      wall_ms += 1; send_request(wall_ms, 120);
      wall_ms += 1; send_request(wall_ms, 121);
      wall_ms += 1; send_request(wall_ms, 80);
      wall_ms += 1; send_request(wall_ms, 79);
      // thresholds beyond the reading range
      apply_settings(1, CSR_W'(TEMP_MAX), 2047, 0, 24'hFF_FFFF, 0);
      wall_ms += 1; send_request(wall_ms, TEMP_W'(TEMP_MIN));
      apply_settings(1, CSR_W'(TEMP_MIN), 2047, 0, 24'hFF_FFFF, 0);
      wall_ms += 1; send_request(wall_ms, TEMP_W'(TEMP_MIN));
      wall_ms += 1; send_request(wall_ms, TEMP_W'(TEMP_MAX));
   endtask

   // disabled: outputs off, phase frozen, timer untouched
   task automatic test_disabled_freeze();
      apply_settings(1, 0, 16, 0, 1000, 1000);
      wall_ms += 5000; send_request(wall_ms, -50);
      wall_ms += 10;   send_request(wall_ms, -60);
      wait_drained();
      write_register(CSR_ENABLED, 0);
      wall_ms += 3000; send_request(wall_ms, -70);
      wall_ms += 3000; send_request(wall_ms, 70);
      wait_drained();
      write_register(CSR_ENABLED, 1);
      wall_ms += 1;    send_request(wall_ms, -80);
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      wait_drained();
      holds_asked++;
      for (int i = 0; i < BACKLOG_ITEMS; i++) begin
         wall_ms += $urandom_range(3);
         send_request(wall_ms, TEMP_W'($urandom));
      end
      wait_drained();
   endtask

   // well-formed time sequences under changing settings, with some noise
   task automatic test_random_sequences();
      int                       sent;
      int                       phase_items;
      int                       step_max;
      int                       spread;
      int                       reading_i;
      logic signed [TEMP_W-1:0] tv;
      logic [CSR_W-1:0]         en_w, target_w, band_w, period_w, heat_w, rest_w;
      sent = 0;
      for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
         en_w     = CSR_W'($urandom);
         target_w = CSR_W'($urandom);
         band_w   = CSR_W'($urandom);
         period_w = CSR_W'($urandom);
         if (phase == 0) begin
            // block enabled, all other registers at their low ends
            en_w[0]               = 1'b1;
            target_w[TEMP_W-1:0]  = TEMP_W'(TEMP_MIN);
            band_w[BAND_W-1:0]    = '0;
            period_w[PERIOD_BITS-1:0] = '0;
            heat_w = '0;
            rest_w = '0;
         end else if (phase == 1) begin
            // all registers at their high ends
            en_w[0]               = 1'b1;
            target_w[TEMP_W-1:0]  = TEMP_W'(TEMP_MAX);
            band_w[BAND_W-1:0]    = '1;
            period_w[PERIOD_BITS-1:0] = '1;
            heat_w = 24'hFF_FFFF;
            rest_w = 24'hFF_FFFF;
         end else begin
            en_w[0] = ($urandom_range(4) != 0);
            case ($urandom_range(3))
               0:       tv = TEMP_W'(TEMP_MIN);
               1:       tv = TEMP_W'(TEMP_MAX);
               2:       tv = TEMP_W'(int'($urandom_range(400)) - 200);
               default: tv = TEMP_W'($urandom);
            endcase
            target_w[TEMP_W-1:0] = tv;
            case ($urandom_range(3))
               0:       band_w[BAND_W-1:0] = '0;
               1:       band_w[BAND_W-1:0] = '1;
               2:       band_w[BAND_W-1:0] = BAND_W'($urandom_range(64));
               default: band_w[BAND_W-1:0] = BAND_W'($urandom);
            endcase
            period_w[PERIOD_BITS-1:0] = PERIOD_BITS'(pick_span(24'h00_FFFF));
            heat_w = pick_span(24'hFF_FFFF);
            rest_w = pick_span(24'hFF_FFFF);
         end
         apply_settings(en_w, target_w, band_w, period_w, heat_w, rest_w);

         case ($urandom_range(3))
            0:       step_max = 1;
            1:       step_max = 4;
            2:       step_max = 20;
            default: step_max = 400;
         endcase
         // some phases start just below the time wrap
         if ($urandom_range(3) == 0)
            wall_ms = '1 - TIME_W'($urandom_range(200));
         phase_items = $urandom_range(250, 100);
         if (phase_items > RANDOM_ITEMS - sent)
            phase_items = RANDOM_ITEMS - sent;

         for (int i = 0; i < phase_items; i++) begin
            if ($urandom_range(9) == 0) begin
               // noise: arbitrary time jump and reading
               wall_ms   = TIME_W'($urandom);
               reading_i = int'(TEMP_W'($urandom) ^ {TEMP_W{1'b0}});
               reading_i = (reading_i > TEMP_MAX) ? reading_i - 2 ** TEMP_W : reading_i;
            end else begin
               // walk forward in time, readings around the band
               wall_ms   = wall_ms + TIME_W'($urandom_range(step_max));
               spread    = int'(cfg_band) + 8;
               reading_i = int'(cfg_target) + int'($urandom_range(2 * spread)) - spread;
               if (reading_i > TEMP_MAX)
                  reading_i = TEMP_MAX;
               if (reading_i < TEMP_MIN)
                  reading_i = TEMP_MIN;
            end
            send_request(wall_ms, TEMP_W'(reading_i));
            pace_sender();
            sent++;
         end
      end
   endtask

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_capture_after_reset();
      test_register_masking();
      test_duty_cycle_timing();
      test_hysteresis_band();
      test_disabled_freeze();
      test_backpressure();
      test_random_sequences();
      wait_drained();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ duty_cycled_hysteresis_thermostat_core.f @@
sv/dcht_pkg.sv
sv/dcht_step.sv
sv/duty_cycled_hysteresis_thermostat_core.sv
test/duty_cycled_hysteresis_thermostat_core_test.sv
